>>> hw/rtl/scvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scvt_pkg
// Shared types and constants of the cache victim tracker.
// ----------------------------------------------------------------------------
package scvt_pkg;

    localparam int TAG_W     = 32;
    localparam int SET_IDX_W = 12;
    localparam int LIMIT_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 2'd3;

    localparam logic [1:0] POLICY_FIFO = 2'd0;
    localparam logic [1:0] POLICY_LRU  = 2'd1;

    localparam logic [3:0] RST_OFFSET_BITS = 4'd5;
    localparam logic [3:0] RST_INDEX_BITS  = 4'd6;
    localparam logic [4:0] RST_WAYS_USED   = 5'd4;
    localparam logic [1:0] RST_POLICY      = POLICY_LRU;

    typedef enum logic [1:0] {
        MODE_FIFO,
        MODE_LRU,
        MODE_NONE
    } mode_t;

    typedef struct packed {
        logic [TAG_W-1:0]     tag;
        logic [SET_IDX_W-1:0] set;
        mode_t                mode;
        logic [LIMIT_W-1:0]   limit;
    } cmd_t;

    typedef struct packed {
        logic             victim_valid;
        logic [TAG_W-1:0] victim_tag;
    } res_t;

endpackage

>>> hw/rtl/scvt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scvt_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module scvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                        wdata,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/scvt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scvt_fifo
// Small register queue used between the tracker stages.
// ----------------------------------------------------------------------------
module scvt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> hw/rtl/scvt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scvt_front
// Configuration registers, address split and command queue.
// ----------------------------------------------------------------------------
module scvt_front #(
    parameter int MAX_SETS      = 256,
    parameter int MAX_WAYS      = 16,
    parameter int ADDRESS_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [scvt_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [scvt_pkg::CFG_DAT_W-1:0] wr_data,
    input  logic                          push,
    output logic                          full,
    input  logic [ADDRESS_WIDTH-1:0]      address,
    input  logic                          clearing,
    output logic                          cmd_valid,
    output scvt_pkg::cmd_t                cmd,
    input  logic                          cmd_pop
);
    import scvt_pkg::*;

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

    logic [3:0] offset_bits_reg;
    logic [3:0] index_bits_reg;
    logic [4:0] ways_used_reg;
    logic [1:0] policy_reg;

    logic [4:0]               shamt;
    logic [ADDRESS_WIDTH-1:0] tag_shift;
    logic [ADDRESS_WIDTH-1:0] set_shift;
    logic [SET_W-1:0]         set_mask;
    logic [SET_W-1:0]         set_idx;
    cmd_t                     new_cmd;
    logic                     q_full;
    logic                     q_empty;
    logic [$bits(cmd_t)-1:0]  q_dout;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= RST_OFFSET_BITS;
            index_bits_reg  <= RST_INDEX_BITS;
            ways_used_reg   <= RST_WAYS_USED;
            policy_reg      <= RST_POLICY;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_OFFSET_BITS: offset_bits_reg <= wr_data[3:0];
                REG_INDEX_BITS:  index_bits_reg  <= wr_data[3:0];
                REG_WAYS_USED:   ways_used_reg   <= wr_data[4:0];
                REG_POLICY:      policy_reg      <= wr_data[1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        shamt     = {1'b0, offset_bits_reg} + {1'b0, index_bits_reg};
        tag_shift = address >> shamt;
        set_shift = address >> offset_bits_reg;
        for (int j = 0; j < SET_W; j++)
        begin
            set_mask[j] = (5'(j) < {1'b0, index_bits_reg});
        end
        set_idx = set_shift[SET_W-1:0] & set_mask;
        if (MAX_SETS == 1)
        begin
            set_idx = '0;
        end

        new_cmd.tag = TAG_W'(tag_shift);
        new_cmd.set = SET_IDX_W'(set_idx);
        case (policy_reg)
            POLICY_FIFO: new_cmd.mode = MODE_FIFO;
            POLICY_LRU:  new_cmd.mode = MODE_LRU;
            default:     new_cmd.mode = MODE_NONE;
        endcase
        // zero ways acts as one, clamp to the physical way count
        if (ways_used_reg == '0)
        begin
            new_cmd.limit = LIMIT_W'(1);
        end
        else if (LIMIT_W'(ways_used_reg) > LIMIT_W'(MAX_WAYS))
        begin
            new_cmd.limit = LIMIT_W'(MAX_WAYS);
        end
        else
        begin
            new_cmd.limit = LIMIT_W'(ways_used_reg);
        end
    end

    assign full = q_full || clearing;

    scvt_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && !full),
        .din   (new_cmd),
        .full  (q_full),
        .pop   (cmd_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    assign cmd_valid = !q_empty;
    assign cmd       = cmd_t'(q_dout);

endmodule

>>> hw/rtl/scvt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scvt_back
// Set row read-modify-write engine: lookup, replacement and age update.
// ----------------------------------------------------------------------------
module scvt_back #(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  scvt_pkg::cmd_t cmd,
    output logic           cmd_pop,
    input  logic           res_full,
    output logic           res_push,
    output scvt_pkg::res_t res,
    output logic           clearing
);
    import scvt_pkg::*;

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int AGE_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_W  = $clog2(MAX_WAYS + 1);
    localparam int META_W = MAX_WAYS * (1 + AGE_W);
    localparam int ROW_W  = MAX_WAYS * TAG_W;
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

    logic             clearing_reg, clearing_next;
    logic [SET_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             busy_reg, busy_next;
    cmd_t             cur_reg;

    logic             start;
    logic [SET_W-1:0] ram_addr;
    logic             meta_we, tag_we;
    logic [META_W-1:0] meta_rd, meta_wd;
    logic [ROW_W-1:0]  tag_rd, tag_wd;

    logic [MAX_WAYS-1:0] vld, nvld, hit_vec, cand;
    logic [AGE_W-1:0]    rk  [MAX_WAYS];
    logic [AGE_W-1:0]    nrk [MAX_WAYS];
    logic [TAG_W-1:0]    tg  [MAX_WAYS];
    logic [WAY_W-1:0]    hit_idx, old_idx, free_idx, target;
    logic                hit_any, free_any, evict;
    logic [CNT_W-1:0]    count;
    logic [AGE_W-1:0]    hit_rk;

    assign clearing = clearing_reg;
    assign start    = !clearing_reg && !busy_reg && cmd_valid && !res_full;
    assign cmd_pop  = start;
    assign res_push = busy_reg;

    always_comb
    begin
        if (busy_reg)
        begin
            ram_addr = cur_reg.set[SET_W-1:0];
        end
        else if (clearing_reg)
        begin
            ram_addr = clr_cnt_reg;
        end
        else
        begin
            ram_addr = cmd.set[SET_W-1:0];
        end
    end

    // sweep the valid and age rows once after reset
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        busy_next     = start;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == SET_W'(MAX_SETS - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            busy_reg     <= 1'b0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
            busy_reg     <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cur_reg <= cmd;
        end
    end

    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            vld[w]     = meta_rd[w];
            rk[w]      = meta_rd[MAX_WAYS + w*AGE_W +: AGE_W];
            tg[w]      = tag_rd[w*TAG_W +: TAG_W];
            hit_vec[w] = vld[w] && (tg[w] == cur_reg.tag);
        end

        // oldest: valid way with no valid way ranked higher, last one wins a tie
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            cand[w] = vld[w];
            for (int v = 0; v < MAX_WAYS; v++)
            begin
                if (vld[v] && (rk[v] > rk[w]))
                begin
                    cand[w] = 1'b0;
                end
            end
        end

        hit_idx  = '0;
        old_idx  = '0;
        free_idx = '0;
        free_any = 1'b0;
        count    = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (hit_vec[w])
            begin
                hit_idx = WAY_W'(w);
            end
            if (cand[w])
            begin
                old_idx = WAY_W'(w);
            end
            count = count + CNT_W'(vld[w]);
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (!vld[w])
            begin
                free_idx = WAY_W'(w);
                free_any = 1'b1;
            end
        end
        hit_any = |hit_vec;
        hit_rk  = rk[hit_idx];
        evict   = !((LIMIT_W'(count) < cur_reg.limit) && free_any);
        target  = evict ? old_idx : free_idx;

        nvld = vld;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            nrk[w] = rk[w];
        end
        tag_wd   = tag_rd;
        meta_we  = clearing_reg;
        tag_we   = 1'b0;
        res.victim_valid = 1'b0;
        res.victim_tag   = '0;

        if (busy_reg && (cur_reg.mode != MODE_NONE))
        begin
            if (hit_any)
            begin
                if (cur_reg.mode == MODE_LRU)
                begin
                    meta_we = 1'b1;
                    for (int w = 0; w < MAX_WAYS; w++)
                    begin
                        if (vld[w] && (rk[w] < hit_rk))
                        begin
                            nrk[w] = rk[w] + 1'b1;
                        end
                    end
                    nrk[hit_idx] = '0;
                end
            end
            else
            begin
                meta_we = 1'b1;
                tag_we  = 1'b1;
                if (evict)
                begin
                    res.victim_valid = 1'b1;
                    res.victim_tag   = tg[old_idx];
                    nvld[target]     = 1'b0;
                end
                for (int w = 0; w < MAX_WAYS; w++)
                begin
                    if (nvld[w] && (rk[w] < AGE_MAX))
                    begin
                        nrk[w] = rk[w] + 1'b1;
                    end
                end
                nvld[target] = 1'b1;
                nrk[target]  = '0;
                tag_wd[32'(target)*TAG_W +: TAG_W] = cur_reg.tag;
            end
        end

        meta_wd[MAX_WAYS-1:0] = nvld;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            meta_wd[MAX_WAYS + w*AGE_W +: AGE_W] = nrk[w];
        end
        if (clearing_reg)
        begin
            meta_wd = '0;
        end
    end

    scvt_ram #(
        .WIDTH (META_W),
        .DEPTH (MAX_SETS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .addr  (ram_addr),
        .wdata (meta_wd),
        .rdata (meta_rd)
    );

    scvt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .addr  (ram_addr),
        .wdata (tag_wd),
        .rdata (tag_rd)
    );

endmodule

>>> hw/rtl/set_assoc_cache_victim_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_victim_tracker_top
// Set-associative cache tag tracker with FIFO or LRU replacement.
// ----------------------------------------------------------------------------
// Each pushed address yields exactly one result: the evicted tag, or no victim
// for a hit, a free fill or the no-tracking policy. The lookup engine handles a
// queued address as a row read, then compare, update and row write in one
// memory port, and takes no new address before it has written the last row.
// After reset, full stays high while the valid/age rows are cleared;
// configuration writes are taken at any time. MAX_SETS must be a power of two.
module set_assoc_cache_victim_tracker_top #(
    parameter int MAX_SETS      = 256,
    parameter int MAX_WAYS      = 16,
    parameter int ADDRESS_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [scvt_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [scvt_pkg::CFG_DAT_W-1:0] wr_data,
    input  logic                           push,
    output logic                           full,
    input  logic [ADDRESS_WIDTH-1:0]       address,
    output logic                           empty,
    input  logic                           pop,
    output logic                           victim_valid,
    output logic [scvt_pkg::TAG_W-1:0]     victim_tag
);
    import scvt_pkg::*;

    logic                    clearing;
    logic                    cmd_valid;
    cmd_t                    cmd;
    logic                    cmd_pop;
    logic                    res_full;
    logic                    res_push;
    res_t                    res;
    logic [$bits(res_t)-1:0] res_dout;
    res_t                    res_out;

    scvt_front #(
        .MAX_SETS      (MAX_SETS),
        .MAX_WAYS      (MAX_WAYS),
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .push      (push),
        .full      (full),
        .address   (address),
        .clearing  (clearing),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    scvt_back #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res),
        .clearing  (clearing)
    );

    scvt_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_dout),
        .empty (empty)
    );

    assign res_out      = res_t'(res_dout);
    assign victim_valid = res_out.victim_valid;
    assign victim_tag   = res_out.victim_tag;

endmodule

>>> hw/rtl/scvt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scvt_checker
// Port-level checks for the victim tracker, bound to the top level.
// ----------------------------------------------------------------------------
module scvt_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       full,
    input logic                       empty,
    input logic                       pop,
    input logic                       victim_valid,
    input logic [scvt_pkg::TAG_W-1:0] victim_tag
);

    // no victim means a zero tag
    a_no_victim_zero_tag: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !victim_valid |-> victim_tag == '0)
        else $error("victim tag nonzero without victim");

    // leaving reset: row clear pending, nothing queued
    a_reset_exit: assert property (@(posedge clk)
        $rose(rst_n) |-> full && empty)
        else $error("queue flags wrong when leaving reset");

    a_flags_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(full) && !$isunknown(empty))
        else $error("queue flags unknown");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(victim_valid) && $stable(victim_tag))
        else $error("waiting result changed");

endmodule

bind set_assoc_cache_victim_tracker_top scvt_checker u_scvt_checker (.*);
